// ----- rtl/scpu_pkg.sv -----
`default_nettype none

package scpu_pkg;

  // Phase resolution of one full turn
  localparam int unsigned PhaseBitsDef = 24;

  // Depth of the queue between the phase front end and the polynomial back end
  localparam int unsigned QueueDepth = 4;

  // Registers in one polynomial lane, from queue head to output register
  localparam int unsigned LaneDepth = 15;

  // Horner steps after the innermost coefficient
  localparam int unsigned NumSteps = 4;

  // round(2^32 / (2*pi)) and round(2*pi * 2^29)
  localparam logic [29:0] InvTwoPiQ32 = 30'd683565276;
  localparam logic [31:0] TwoPiQ29    = 32'd3373259426;

  // Q30 constants
  localparam logic [31:0] OneQ30 = 32'd1073741824;
  localparam logic [31:0] RndQ30 = 32'd536870912;
  localparam logic [31:0] C9Q30  = 32'd2794;

  // Queue fill status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } scpu_q_stat_t;

  // Constant added after each Horner multiply, innermost first
  function automatic logic signed [31:0] horner_coef(input int unsigned step);
    logic signed [31:0] c;
    unique case (step)
      0:       c = -32'sd212680;
      1:       c = 32'sd8947518;
      2:       c = -32'sd178956867;
      default: c = 32'sd1073741824;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sine_cosine_polynomial_unit_core.sv -----
`default_nettype none

// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[31:0] angle, Q8.24
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0] sine, [63:32] cosine, Q2.30
//
// One transaction in and one out per cycle when both sides keep up.
// An angle passes the front registers, then the queue, then the back end; the back end is a
// two-lane pipeline of seven multiplies each, each multiply in a register stage of its own.
// A 4-entry queue decouples the angle scaling front end from the polynomial back end.
// An output stall freezes the back end; the front keeps accepting until the queue fills.
// Reset clears valid bits, queue pointers and the queue count only; no clearing pass.

module sine_cosine_polynomial_unit_core #(
  parameter int unsigned PHASE_BITS = scpu_pkg::PhaseBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [31:0] sine, [63:32] cosine
);
  import scpu_pkg::*;

  scpu_q_stat_t            q_stat;
  logic                    push, pop;
  logic [PHASE_BITS-1:0]   f_sphase, f_cphase, b_sphase, b_cphase;
  logic [31:0]             sine, cosine;

  scpu_front #(.PhaseBits(PHASE_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .angle_i    (s_axis_tdata),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .sphase_o   (f_sphase),
    .cphase_o   (f_cphase)
  );

  scpu_queue #(.Width(2 * PHASE_BITS), .Depth(QueueDepth)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({f_cphase, f_sphase}),
    .pop_i  (pop),
    .data_o ({b_cphase, b_sphase}),
    .stat_o (q_stat)
  );

  scpu_back #(.PhaseBits(PHASE_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .sphase_i   (b_sphase),
    .cphase_i   (b_cphase),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sine_o     (sine),
    .cosine_o   (cosine)
  );

  assign m_axis_tdata = {cosine, sine};

endmodule

`default_nettype wire

// ----- rtl/scpu_front.sv -----
`default_nettype none

module scpu_front #(
  parameter int unsigned PhaseBits = scpu_pkg::PhaseBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_tvalid_i,
  output logic                       s_tready_o,
  input  wire logic [31:0]           angle_i,
  input  wire scpu_pkg::scpu_q_stat_t q_stat_i,
  output logic                       push_o,
  output logic [PhaseBits-1:0]       sphase_o,
  output logic [PhaseBits-1:0]       cphase_o
);
  import scpu_pkg::*;

  localparam int unsigned Shift = 56 - PhaseBits;
  localparam logic [PhaseBits-1:0] Quarter = PhaseBits'(1) << (PhaseBits - 2);

  logic [1:0]           vld_q;
  logic                 en;
  logic                 neg1_q, neg2_q;
  logic [31:0]          mag1_q;
  logic [61:0]          prod_q;
  logic [PhaseBits-1:0] pm;

  // Advance while the last stage is empty or can push
  assign en         = !vld_q[1] || !q_stat_i.full;
  assign s_tready_o = en;
  assign push_o     = vld_q[1] && !q_stat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[0], s_tvalid_i};
    end
  end

  // Take magnitude, then scale to turns
  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q <= angle_i[31];
      mag1_q <= angle_i[31] ? (~angle_i + 32'd1) : angle_i;
      neg2_q <= neg1_q;
      prod_q <= 62'(mag1_q) * 62'(InvTwoPiQ32);
    end
  end

  // Truncate toward zero, wrap to one turn, derive the cosine phase
  assign pm       = prod_q[Shift +: PhaseBits];
  assign sphase_o = neg2_q ? (~pm + PhaseBits'(1)) : pm;
  assign cphase_o = sphase_o + Quarter;

endmodule

`default_nettype wire

// ----- rtl/scpu_queue.sv -----
`default_nettype none

module scpu_queue #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = scpu_pkg::QueueDepth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire logic [Width-1:0]       data_i,
  input  wire logic                   pop_i,
  output logic [Width-1:0]            data_o,
  output scpu_pkg::scpu_q_stat_t      stat_o
);
  import scpu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_q];

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("queue pop while empty");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- rtl/scpu_lane.sv -----
`default_nettype none

module scpu_lane #(
  parameter int unsigned PhaseBits = scpu_pkg::PhaseBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [PhaseBits-1:0] phase_i,
  output logic [31:0]               result_o
);
  import scpu_pkg::*;

  localparam int unsigned MW = PhaseBits - 1;
  localparam int unsigned PW = MW + 32;
  localparam logic [PhaseBits-1:0] Quarter = PhaseBits'(1) << (PhaseBits - 2);
  localparam logic [PhaseBits-1:0] Half    = PhaseBits'(1) << (PhaseBits - 1);

  // Fold stage
  logic [PhaseBits-1:0] w, fold;
  logic                 neg0;
  logic [MW-1:0]        m1_q;
  logic                 ng1_q;

  assign w    = phase_i + Quarter;
  assign fold = (w > Half) ? (~w + PhaseBits'(1)) : w;
  assign neg0 = fold < Quarter;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q  <= neg0 ? MW'(Quarter - fold) : MW'(fold - Quarter);
      ng1_q <= neg0;
    end
  end

  // Offset to radians, then square
  logic [PW-1:0] prod2_q;
  logic          ng2_q;
  logic [PW:0]   xsum;
  logic [30:0]   x3_q;
  logic          ng3_q;
  logic [61:0]   sq4_q;
  logic [30:0]   x4_q;
  logic          ng4_q;
  logic [62:0]   x2sum;

  assign xsum  = {1'b0, prod2_q} + (PW + 1)'(Quarter);
  assign x2sum = {1'b0, sq4_q} + 63'(RndQ30);

  // Horner stage inputs; index 0 holds the innermost coefficient
  logic [31:0] a_x2 [NumSteps+1];
  logic [30:0] a_x  [NumSteps+1];
  logic        a_ng [NumSteps+1];
  logic        a_s  [NumSteps+1];
  logic [31:0] a_m  [NumSteps+1];
  logic [31:0] h_x2_q;
  logic [30:0] h_x_q;
  logic        h_ng_q;

  assign a_x2[0] = h_x2_q;
  assign a_x[0]  = h_x_q;
  assign a_ng[0] = h_ng_q;
  assign a_s[0]  = 1'b0;
  assign a_m[0]  = C9Q30;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod2_q <= PW'(m1_q) * PW'(TwoPiQ29);
      ng2_q   <= ng1_q;
      x3_q    <= xsum[MW +: 31];
      ng3_q   <= ng2_q;
      sq4_q   <= 62'(x3_q) * 62'(x3_q);
      x4_q    <= x3_q;
      ng4_q   <= ng3_q;
      h_x2_q  <= x2sum[61:30];
      h_x_q   <= x4_q;
      h_ng_q  <= ng4_q;
    end
  end

  // One multiply stage and one accumulate stage per step
  for (genvar j = 0; j < NumSteps; j++) begin : g_step
    logic [63:0]        p_q;
    logic [31:0]        x2_q;
    logic [30:0]        x_q;
    logic               ng_q;
    logic               s_q;
    logic [64:0]        psum;
    logic [34:0]        p;
    logic signed [35:0] sp;
    logic signed [35:0] v;
    logic [31:0]        o_x2_q;
    logic [30:0]        o_x_q;
    logic               o_ng_q;
    logic               o_s_q;
    logic [31:0]        o_m_q;

    assign psum = {1'b0, p_q} + 65'(RndQ30);
    assign p    = psum[64:30];
    assign sp   = s_q ? -$signed({1'b0, p}) : $signed({1'b0, p});
    assign v    = 36'(horner_coef(j)) + sp;

    assign a_x2[j+1] = o_x2_q;
    assign a_x[j+1]  = o_x_q;
    assign a_ng[j+1] = o_ng_q;
    assign a_s[j+1]  = o_s_q;
    assign a_m[j+1]  = o_m_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q    <= 64'(a_x2[j]) * 64'(a_m[j]);
        x2_q   <= a_x2[j];
        x_q    <= a_x[j];
        ng_q   <= a_ng[j];
        s_q    <= a_s[j];
        o_x2_q <= x2_q;
        o_x_q  <= x_q;
        o_ng_q <= ng_q;
        o_s_q  <= v[35];
        o_m_q  <= v[35] ? 32'(-v) : 32'(v);
      end
    end
  end

  // Final multiply by x, clamp to [0, one], apply the fold sign
  logic [62:0] f_q;
  logic        fs_q, fng_q;
  logic [63:0] rsum;
  logic [33:0] r;
  logic [31:0] rmag;

  assign rsum = {1'b0, f_q} + 64'(RndQ30);
  assign r    = rsum[63:30];

  always_comb begin
    if (fs_q) begin
      rmag = '0;
    end else if (r > 34'(OneQ30)) begin
      rmag = OneQ30;
    end else begin
      rmag = r[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q      <= 63'(a_x[NumSteps]) * 63'(a_m[NumSteps]);
      fs_q     <= a_s[NumSteps];
      fng_q    <= a_ng[NumSteps];
      result_o <= fng_q ? (~rmag + 32'd1) : rmag;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scpu_back.sv -----
`default_nettype none

module scpu_back #(
  parameter int unsigned PhaseBits = scpu_pkg::PhaseBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire scpu_pkg::scpu_q_stat_t q_stat_i,
  input  wire logic [PhaseBits-1:0]   sphase_i,
  input  wire logic [PhaseBits-1:0]   cphase_i,
  output logic                        pop_o,
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic [31:0]                 sine_o,
  output logic [31:0]                 cosine_o
);
  import scpu_pkg::*;

  logic [LaneDepth-1:0] vld_q;
  logic                 en;

  // Advance the whole back end unless a result waits at the output and is not taken
  assign en         = !vld_q[LaneDepth-1] || m_tready_i;
  assign pop_o      = en && !q_stat_i.empty;
  assign m_tvalid_o = vld_q[LaneDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LaneDepth-2:0], pop_o};
    end
  end

  scpu_lane #(.PhaseBits(PhaseBits)) u_sin (
    .clk_i    (clk_i),
    .en_i     (en),
    .phase_i  (sphase_i),
    .result_o (sine_o)
  );

  scpu_lane #(.PhaseBits(PhaseBits)) u_cos (
    .clk_i    (clk_i),
    .en_i     (en),
    .phase_i  (cphase_i),
    .result_o (cosine_o)
  );

  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed(sine_o) <= $signed(OneQ30))
                && ($signed(sine_o) >= -$signed(OneQ30)))
    else $error("sine out of range");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed(cosine_o) <= $signed(OneQ30))
                && ($signed(cosine_o) >= -$signed(OneQ30)))
    else $error("cosine out of range");

  a_not_both_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (sine_o != '0) || (cosine_o != '0))
    else $error("sine and cosine both zero");

endmodule

`default_nettype wire
